/* design/c_string_escape_decoder_top_defines.svh */
// ----------------------------------------------------------------------------
// c_string_escape_decoder_top_defines.svh
// Assertion macros for the string escape decoder. Define ASSERT_OFF to drop
// all checks.
// ----------------------------------------------------------------------------
`ifndef C_STRING_ESCAPE_DECODER_TOP_DEFINES_SVH
`define C_STRING_ESCAPE_DECODER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication, clocked on clk, off during reset
`define CSED_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define CSED_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CSED_ASSERT_NOW(label, ante, cons, msg)
`define CSED_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* design/csed_pkg.sv */
// ----------------------------------------------------------------------------
// csed_pkg
// Types, character codes and lookup functions for the escape decoder.
// ----------------------------------------------------------------------------
package csed_pkg;

	// decode mode codes
	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ESCAPE = 2'd1;
	localparam logic [1:0] MODE_OCTAL  = 2'd2;
	localparam logic [1:0] MODE_HEX    = 2'd3;

	// character codes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// result buffer depth: one draining, up to two arriving
	localparam int unsigned QDEPTH = 3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_last;
		logic       unknown_escape;
		logic       out_of_range;
	} res_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] value;
	} simple_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] digit;
	} digit_t;

	// simple escapes: n t v b r f a \ ? ' "
	function automatic simple_t simple_escape(input logic [7:0] b);
		simple_t r;
		r.hit = 1'b1;
		r.value = b;
		case (b)
			8'h6E: r.value = 8'h0A;
			8'h74: r.value = 8'h09;
			8'h76: r.value = 8'h0B;
			8'h62: r.value = 8'h08;
			8'h72: r.value = 8'h0D;
			8'h66: r.value = 8'h0C;
			8'h61: r.value = 8'h07;
			8'h5C: r.value = 8'h5C;
			8'h3F: r.value = 8'h3F;
			8'h27: r.value = 8'h27;
			8'h22: r.value = 8'h22;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic digit_t hex_digit(input logic [7:0] b);
		digit_t r;
		r.hit = 1'b1;
		r.digit = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r.digit = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r.digit = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r.digit = 4'(b - 8'h37);
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage

/* design/csed_if.sv */
// ----------------------------------------------------------------------------
// csed_if
// Valid/ready channels of the escape decoder: literal bytes in, decoded
// results out.
// ----------------------------------------------------------------------------
interface csed_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface csed_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_last;
	logic       unknown_escape;
	logic       out_of_range;

	modport source (output valid, output out_byte, output is_last,
		output unknown_escape, output out_of_range, input ready);
	modport sink (input valid, input out_byte, input is_last,
		input unknown_escape, input out_of_range, output ready);
endinterface

/* design/c_string_escape_decoder_top.sv */
// ----------------------------------------------------------------------------
// c_string_escape_decoder_top
// Decodes the bytes of a C string literal (after the opening quote) into
// plain bytes: simple, octal and hex escapes, terminator on closing quote.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                          per xact
//  -------   ---  -----------------------------------------------  --------
//  text      in   in_byte[7:0]                                     1 byte
//  decoded   out  out_byte[7:0] is_last unknown_escape out_of_range 0..2 per byte
//
// One byte per cycle sustained; a result passes through the input register,
// then the result buffer, before it leaves. A byte with two results (a
// non-backslash byte closing a numeric escape, or 8/9 right after a backslash)
// leaves two entries in the 3-entry buffer, so input stalls while the second
// drains. Input is taken when stage 1 is empty or the buffer holds at most one
// result; decoded stalls back up through the buffer into text.ready.
// arst_n clears the mode machine, escape value, overflow flag and buffer.
// ----------------------------------------------------------------------------
`include "c_string_escape_decoder_top_defines.svh"

module c_string_escape_decoder_top
	import csed_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	csed_text_if.sink     text,
	csed_result_if.source decoded
);

	localparam int unsigned PW = $clog2(QDEPTH);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// decoder state
	logic [1:0] mode_q;
	logic [7:0] value_q;
	logic       ovf_q;

	// result buffer
	res_t          buf_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW-1:0] count_q;

	logic room;
	logic adv;
	logic pop;

	// decode outputs
	logic [1:0] n_push;
	res_t       res0;
	res_t       res1;
	logic [1:0] mode_d;
	logic [7:0] value_d;
	logic       ovf_d;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// room for the worst case of two results from the byte in stage 1
	assign room       = (count_q <= PW'(QDEPTH - 2));
	assign adv        = valid_s1 && room;
	assign text.ready = !valid_s1 || room;
	assign pop        = decoded.valid && decoded.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.in_byte;
		end
	end

	// ---- decode: one byte against the current mode ----
	always_comb begin
		simple_t    se;
		digit_t     hd;
		logic       is_oct;
		logic       is_dec;
		logic       dig_ok;
		logic       dig_ovf;
		logic [7:0] dig_val;
		logic       txt_emit;
		res_t       txt_res;
		logic [1:0] txt_mode;

		se     = simple_escape(byte_s1);
		hd     = hex_digit(byte_s1);
		is_oct = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_SEVEN);
		is_dec = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);

		// ordinary text handling of this byte
		txt_emit = (byte_s1 != CH_BSLASH);
		txt_mode = txt_emit ? MODE_NORMAL : MODE_ESCAPE;
		txt_res  = '{out_byte: byte_s1, is_last: 1'b0,
			unknown_escape: 1'b0, out_of_range: 1'b0};
		if (byte_s1 == CH_QUOTE) begin
			txt_res = '{out_byte: 8'h00, is_last: 1'b1,
				unknown_escape: 1'b0, out_of_range: 1'b0};
		end

		// digit accumulation for the numeric modes
		if (mode_q == MODE_OCTAL) begin
			dig_ok  = is_oct;
			dig_ovf = (value_q[7:5] != 3'd0);
			dig_val = {value_q[4:0], byte_s1[2:0]};
		end else begin
			dig_ok  = hd.hit;
			dig_ovf = (value_q[7:4] != 4'd0);
			dig_val = {value_q[3:0], hd.digit};
		end

		n_push  = 2'd0;
		res0    = txt_res;
		res1    = txt_res;
		mode_d  = mode_q;
		value_d = value_q;
		ovf_d   = ovf_q;

		case (mode_q)
			MODE_NORMAL: begin
				n_push = {1'b0, txt_emit};
				mode_d = txt_mode;
				if (byte_s1 == CH_QUOTE) begin
					value_d = 8'h00;
					ovf_d   = 1'b0;
				end
			end
			MODE_ESCAPE: begin
				value_d = 8'h00;
				ovf_d   = 1'b0;
				if (se.hit) begin
					n_push = 2'd1;
					res0   = '{out_byte: se.value, is_last: 1'b0,
						unknown_escape: 1'b0, out_of_range: 1'b0};
					mode_d = MODE_NORMAL;
				end else if (is_oct) begin
					mode_d  = MODE_OCTAL;
					value_d = {5'd0, byte_s1[2:0]};
				end else if (is_dec) begin
					// '8' or '9': empty octal escape, then the digit as text
					n_push = 2'd2;
					res0   = '{out_byte: 8'h00, is_last: 1'b0,
						unknown_escape: 1'b0, out_of_range: 1'b0};
					res1   = '{out_byte: byte_s1, is_last: 1'b0,
						unknown_escape: 1'b0, out_of_range: 1'b0};
					mode_d = MODE_NORMAL;
				end else if (byte_s1 == CH_X) begin
					mode_d = MODE_HEX;
				end else begin
					n_push = 2'd1;
					res0   = '{out_byte: byte_s1, is_last: 1'b0,
						unknown_escape: 1'b1, out_of_range: 1'b0};
					mode_d = MODE_NORMAL;
				end
			end
			MODE_OCTAL, MODE_HEX: begin
				if (dig_ok) begin
					value_d = dig_val;
					ovf_d   = ovf_q | dig_ovf;
				end else begin
					// close the escape, then treat the byte as text
					res0    = '{out_byte: value_q, is_last: 1'b0,
						unknown_escape: 1'b0, out_of_range: ovf_q};
					res1    = txt_res;
					n_push  = txt_emit ? 2'd2 : 2'd1;
					mode_d  = txt_mode;
					value_d = 8'h00;
					ovf_d   = 1'b0;
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			value_q <= 8'h00;
			ovf_q   <= 1'b0;
		end else if (adv) begin
			mode_q  <= mode_d;
			value_q <= value_d;
			ovf_q   <= ovf_d;
		end
	end

	// ---- result buffer ----
	logic [1:0] push_n;
	assign push_n = adv ? n_push : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end else if (push_n == 2'd2) begin
				wr_ptr_q <= ptr_inc(ptr_inc(wr_ptr_q));
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + PW'(push_n) - PW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			buf_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			buf_q[ptr_inc(wr_ptr_q)] <= res1;
		end
	end

	res_t head;
	assign head                   = buf_q[rd_ptr_q];
	assign decoded.valid          = (count_q != '0);
	assign decoded.out_byte       = head.out_byte;
	assign decoded.is_last        = head.is_last;
	assign decoded.unknown_escape = head.unknown_escape;
	assign decoded.out_of_range   = head.out_of_range;

	// ---- checks ----
	`CSED_ASSERT_NEXT(a_quote_resets, adv && (mode_q != MODE_ESCAPE) && (byte_s1 == CH_QUOTE),
		(mode_q == MODE_NORMAL) && (value_q == 8'h00) && !ovf_q,
		"decoder state not cleared after terminator")
	`CSED_ASSERT_NOW(a_ovf_numeric, ovf_q, (mode_q == MODE_OCTAL) || (mode_q == MODE_HEX),
		"overflow flag set outside a numeric escape")
	`CSED_ASSERT_NOW(a_flags_exclusive, decoded.valid && decoded.out_of_range,
		!decoded.is_last && !decoded.unknown_escape,
		"out_of_range result also marked last or unknown")

endmodule
